[rtl/kwsc_pkg.sv]
// Shared types and constants for the keyword substitution cipher core.
// No dependencies.
package kwsc_pkg;

   localparam int unsigned LETTER_COUNT = 26;
   localparam int unsigned LETTER_W     = 5;
   localparam int unsigned BYTE_W       = 8;
   localparam int unsigned OP_W         = 2;

   localparam logic [BYTE_W-1:0] CHAR_UPPER_A = 8'h41;
   localparam logic [BYTE_W-1:0] CHAR_UPPER_Z = 8'h5A;
   localparam logic [BYTE_W-1:0] CHAR_LOWER_A = 8'h61;
   localparam logic [BYTE_W-1:0] CHAR_LOWER_Z = 8'h7A;

   localparam logic [LETTER_W-1:0] LAST_LETTER = LETTER_W'(LETTER_COUNT - 1);

   typedef enum logic [OP_W-1:0] {
      OP_KEY_LETTER = 2'd0,
      OP_KEY_END    = 2'd1,
      OP_TEXT       = 2'd2,
      OP_UNUSED     = 2'd3
   } op_type;

   typedef struct packed {
      logic load_key;
      logic fill_start;
      logic fill_step;
      logic load_rsp;
   } cmd_type;

   typedef struct packed {
      logic tables_ready;
      logic fill_last;
   } status_type;

endpackage

[rtl/keyword_substitution_cipher_core.sv]
// Keyword substitution cipher core. Key letters (case folded, non-letters and
// repeats ignored) and text bytes are taken one item per cycle; a text item's
// result is held in an output register, and the next item is accepted only once
// that result leaves or in the cycle it leaves, so a stalled result stalls the
// input. The first end-of-key item starts a walk from Z down to A that appends the
// unused letters, one letter per cycle, during which req_tready is low; a repeated
// end of key is accepted and changes nothing.
// The inverse table is written alongside the forward table, so no separate pass
// is needed. Text before end of key passes through.
// Depends on kwsc_pkg, kwsc_ctrl and kwsc_datapath.
module keyword_substitution_cipher_core (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] in_byte
   input  logic [1:0] req_tuser,   // [1:0] operation
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] out_byte
   input  logic       csr_wr_en,
   input  logic       csr_wr_data  // decrypt_mode
);
   import kwsc_pkg::*;

   cmd_type    cmd;
   status_type status;

   kwsc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_op     (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   kwsc_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .in_byte     (req_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .cmd         (cmd),
      .status      (status),
      .rsp_byte    (rsp_tdata)
   );

   a_text_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && (req_tuser == OP_TEXT)) |=> rsp_tvalid)
      else $error("text item did not produce a result");

   a_fill_blocks_input: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && (req_tuser == OP_KEY_END) && !status.tables_ready)
      |=> !req_tready)
      else $error("input accepted during alphabet fill");

   a_no_key_after_ready: assert property (@(posedge clock) disable iff (reset)
      status.tables_ready |-> !cmd.load_key && !cmd.fill_start)
      else $error("key update after tables ready");

endmodule

[rtl/kwsc_ctrl.sv]
// Controller for the keyword substitution cipher core: accept logic, fill
// sequencing and the result valid flag. Depends on kwsc_pkg.
module kwsc_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [kwsc_pkg::OP_W-1:0] req_op,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   input  kwsc_pkg::status_type   status,
   output kwsc_pkg::cmd_type      cmd
);
   import kwsc_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_FILL = 2'b10
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      req_fire;
   op_type    op;

   assign op         = op_type'(req_op);
   assign req_tready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_tready);
   assign req_fire   = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;

   always_comb begin
      state_in       = state_ff;
      cmd.load_key   = 1'b0;
      cmd.fill_start = 1'b0;
      cmd.fill_step  = 1'b0;
      cmd.load_rsp   = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               unique case (op)
                  OP_KEY_LETTER: cmd.load_key = !status.tables_ready;
                  OP_KEY_END: begin
                     if (!status.tables_ready) begin
                        cmd.fill_start = 1'b1;
                        state_in       = ST_FILL;
                     end
                  end
                  OP_TEXT:   cmd.load_rsp = 1'b1;
                  default:   ;
               endcase
            end
         end
         ST_FILL: begin
            cmd.fill_step = 1'b1;
            if (status.fill_last) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      priority if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

[rtl/kwsc_datapath.sv]
// Datapath for the keyword substitution cipher core: letter set, cipher and
// inverse tables, fill counter, mode register and result byte. Depends on kwsc_pkg.
module kwsc_datapath (
   input  logic                       clock,
   input  logic                       reset,
   input  logic [kwsc_pkg::BYTE_W-1:0] in_byte,
   input  logic                       csr_wr_en,
   input  logic                       csr_wr_data,
   input  kwsc_pkg::cmd_type          cmd,
   output kwsc_pkg::status_type       status,
   output logic [kwsc_pkg::BYTE_W-1:0] rsp_byte
);
   import kwsc_pkg::*;

   logic [LETTER_W-1:0]     cipher_ff  [LETTER_COUNT];
   logic [LETTER_W-1:0]     inverse_ff [LETTER_COUNT];
   logic [LETTER_COUNT-1:0] used_ff, used_in;
   logic [LETTER_W-1:0]     slots_ff, slots_in;
   logic                    ready_ff, ready_in;
   logic [LETTER_W-1:0]     fill_idx_ff, fill_idx_in;
   logic                    decrypt_ff;
   logic [BYTE_W-1:0]       rsp_byte_ff;

   logic                    is_upper, is_lower, is_letter;
   logic [LETTER_W-1:0]     in_idx;
   logic [LETTER_W-1:0]     add_idx;
   logic                    add_valid, add_en;
   logic [LETTER_W-1:0]     mapped;
   logic [BYTE_W-1:0]       rsp_in;

   assign is_upper  = (in_byte >= CHAR_UPPER_A) && (in_byte <= CHAR_UPPER_Z);
   assign is_lower  = (in_byte >= CHAR_LOWER_A) && (in_byte <= CHAR_LOWER_Z);
   assign is_letter = is_upper || is_lower;

   always_comb begin
      logic [BYTE_W-1:0] diff;
      diff   = is_upper ? (in_byte - CHAR_UPPER_A) : (in_byte - CHAR_LOWER_A);
      in_idx = diff[LETTER_W-1:0];
   end

   // Shared append: key letters from the input, fill letters from Z down to A.
   assign add_idx   = cmd.fill_step ? fill_idx_ff : in_idx;
   assign add_valid = cmd.fill_step || (cmd.load_key && is_letter);
   assign add_en    = add_valid && !ready_ff && (slots_ff < LETTER_W'(LETTER_COUNT))
                      && !used_ff[add_idx];

   always_comb begin
      used_in     = used_ff;
      slots_in    = slots_ff;
      ready_in    = ready_ff;
      fill_idx_in = fill_idx_ff;
      if (add_en) begin
         used_in[add_idx] = 1'b1;
         slots_in         = slots_ff + LETTER_W'(1);
      end
      if (cmd.fill_start) begin
         fill_idx_in = LAST_LETTER;
      end else if (cmd.fill_step) begin
         fill_idx_in = fill_idx_ff - LETTER_W'(1);
         if (fill_idx_ff == '0) begin
            ready_in = 1'b1;
         end
      end
   end

   assign mapped = decrypt_ff ? inverse_ff[in_idx] : cipher_ff[in_idx];

   always_comb begin
      rsp_in = in_byte;
      if (ready_ff && is_letter) begin
         rsp_in = (is_lower ? CHAR_LOWER_A : CHAR_UPPER_A) + {3'b000, mapped};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff    <= '0;
         slots_ff   <= '0;
         ready_ff   <= 1'b0;
         decrypt_ff <= 1'b0;
      end else begin
         used_ff  <= used_in;
         slots_ff <= slots_in;
         ready_ff <= ready_in;
         if (csr_wr_en) begin
            decrypt_ff <= csr_wr_data;
         end
      end
   end

   // Inverse entry is written together with the forward entry.
   always_ff @(posedge clock) begin
      fill_idx_ff <= fill_idx_in;
      if (add_en) begin
         cipher_ff[slots_ff] <= add_idx;
         inverse_ff[add_idx] <= slots_ff;
      end
      if (cmd.load_rsp) begin
         rsp_byte_ff <= rsp_in;
      end
   end

   assign status.tables_ready = ready_ff;
   assign status.fill_last    = (fill_idx_ff == '0);
   assign rsp_byte            = rsp_byte_ff;

endmodule

[verif/tb_keyword_substitution_cipher_core.sv]
// Testbench for keyword_substitution_cipher_core: a directed table, then random text
// under both cipher directions, each out_byte checked against a row's known byte or a local cipher predictor.
// Depends on kwsc_pkg and keyword_substitution_cipher_core.
module tb_keyword_substitution_cipher_core;
   timeunit 1ns;
   timeprecision 1ps;

   import kwsc_pkg::*;

   typedef struct {
      op_type     op;
      logic [7:0] data;
      bit         known;
      logic [7:0] out;
   } dir_row_type;

   logic       clock       = 1'b0;
   logic       reset       = 1'b1;
   logic       req_tvalid  = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata   = 8'h00;
   logic [1:0] req_tuser   = OP_KEY_LETTER;
   logic       rsp_tvalid;
   logic       rsp_tready  = 1'b0;
   logic [7:0] rsp_tdata;
   logic       csr_wr_en   = 1'b0;
   logic       csr_wr_data = 1'b0;

   // cipher predictor state
   logic [LETTER_W-1:0] cipher_tab  [LETTER_COUNT];
   logic [LETTER_W-1:0] inverse_tab [LETTER_COUNT];
   logic [LETTER_COUNT-1:0] letters_taken = '0;
   int   slot_count   = 0;
   bit   tables_built = 1'b0;
   bit   decrypt_on   = 1'b0;

   logic [7:0] out_bytes_due [$];
   int   mismatch_count = 0;
   bit   req_burst      = 1'b0;
   int   req_no_gap     = 0;
   bit   rsp_burst      = 1'b0;
   bit   rsp_hold       = 1'b0;

   dir_row_type directed_rows [26] = '{
      '{OP_TEXT,       8'h41, 1'b1, 8'h41},   // text before key end passes through
      '{OP_TEXT,       8'h7A, 1'b1, 8'h7A},
      '{OP_TEXT,       8'h00, 1'b1, 8'h00},
      '{OP_TEXT,       8'hFF, 1'b1, 8'hFF},
      '{OP_KEY_LETTER, 8'h4B, 1'b0, 8'h00},
      '{OP_KEY_LETTER, 8'h6B, 1'b0, 8'h00},   // repeat, other case
      '{OP_KEY_LETTER, 8'h33, 1'b0, 8'h00},   // non-letter
      '{OP_KEY_LETTER, 8'hFF, 1'b0, 8'h00},
      '{OP_UNUSED,     8'h55, 1'b0, 8'h00},
      '{OP_KEY_LETTER, 8'h7A, 1'b0, 8'h00},
      '{OP_KEY_LETTER, 8'h41, 1'b0, 8'h00},
      '{OP_TEXT,       8'h6D, 1'b1, 8'h6D},
      '{OP_KEY_END,    8'h00, 1'b0, 8'h00},
      '{OP_KEY_END,    8'hFF, 1'b0, 8'h00},   // repeated end of key
      '{OP_KEY_LETTER, 8'h42, 1'b0, 8'h00},   // key letter after end
      '{OP_TEXT,       8'h41, 1'b0, 8'h00},
      '{OP_TEXT,       8'h5A, 1'b0, 8'h00},
      '{OP_TEXT,       8'h61, 1'b0, 8'h00},
      '{OP_TEXT,       8'h7A, 1'b0, 8'h00},
      '{OP_TEXT,       8'h40, 1'b1, 8'h40},   // neighbors of the letter ranges
      '{OP_TEXT,       8'h5B, 1'b1, 8'h5B},
      '{OP_TEXT,       8'h60, 1'b1, 8'h60},
      '{OP_TEXT,       8'h7B, 1'b1, 8'h7B},
      '{OP_TEXT,       8'h00, 1'b1, 8'h00},
      '{OP_TEXT,       8'hFF, 1'b1, 8'hFF},
      '{OP_UNUSED,     8'hAA, 1'b0, 8'h00}
   };

   keyword_substitution_cipher_core DUT (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic int letter_of(input logic [7:0] c);
      if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z)
         return int'(c - CHAR_UPPER_A);
      if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z)
         return int'(c - CHAR_LOWER_A);
      return LETTER_COUNT;
   endfunction

   function automatic void cipher_append(input int idx);
      if (idx < LETTER_COUNT && slot_count < LETTER_COUNT) begin
         if (!letters_taken[idx]) begin
            letters_taken[idx]     = 1'b1;
            cipher_tab[slot_count] = LETTER_W'(idx);
            slot_count++;
         end
      end
   endfunction

   // returns 1 when the item yields an out_byte
   function automatic bit cipher_step(input op_type op, input logic [7:0] c,
                                      output logic [7:0] o);
      int idx;
      logic [LETTER_W-1:0] m;
      idx = letter_of(c);
      o   = c;
      case (op)
         OP_KEY_LETTER: begin
            if (!tables_built)
               cipher_append(idx);
         end
         OP_KEY_END: begin
            if (!tables_built) begin
               for (int k = 0; k < LETTER_COUNT; k++)
                  cipher_append(LETTER_COUNT - 1 - k);
               for (int k = 0; k < LETTER_COUNT; k++)
                  inverse_tab[cipher_tab[k]] = LETTER_W'(k);
               tables_built = 1'b1;
            end
         end
         OP_TEXT: begin
            if (tables_built && idx < LETTER_COUNT) begin
               m = decrypt_on ? inverse_tab[idx] : cipher_tab[idx];
               o = ((c >= CHAR_LOWER_A) ? CHAR_LOWER_A : CHAR_UPPER_A) + 8'(m);
            end
            return 1'b1;
         end
         default: ;
      endcase
      return 1'b0;
   endfunction

   function automatic logic [7:0] pick_letter();
      logic [7:0] base;
      base = $urandom_range(0, 1) ? CHAR_LOWER_A : CHAR_UPPER_A;
      return base + 8'($urandom_range(0, LETTER_COUNT - 1));
   endfunction

   task automatic offer_item(input op_type op, input logic [7:0] data, input bit known,
                             input logic [7:0] known_out);
      int gap;
      logic [7:0] predicted;
      gap = (req_no_gap > 0 || req_burst) ? 0 : $urandom_range(0, 19);
      if (req_no_gap > 0)
         req_no_gap--;
      if ($urandom_range(0, 63) == 0)
         req_burst = !req_burst;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= data;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      if (cipher_step(op, data, predicted))
         out_bytes_due.push_back(known ? known_out : predicted);
   endtask

   // only while idle; the wait covers a key-end fill still in progress
   task automatic set_decrypt(input bit mode);
      req_tvalid <= 1'b0;
      while (out_bytes_due.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= mode;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      decrypt_on = mode;
   endtask

   // result side
   initial begin
      logic [7:0] want;
      int gap;
      while (reset) @(posedge clock);
      forever begin
         if (rsp_hold) begin
            rsp_hold = 1'b0;
            rsp_tready <= 1'b0;
            repeat (150) @(posedge clock);
         end else begin
            gap = rsp_burst ? 0 : $urandom_range(0, 19);
            if ($urandom_range(0, 63) == 0)
               rsp_burst = !rsp_burst;
            if (gap > 0) begin
               rsp_tready <= 1'b0;
               repeat (gap) @(posedge clock);
            end
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
         if (out_bytes_due.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("out_byte %h arrived with none expected", rsp_tdata);
         end else begin
            want = out_bytes_due.pop_front();
            if (rsp_tdata !== want) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("out_byte mismatch: expected %h actual %h", want, rsp_tdata);
            end
         end
      end
   end

   // stimulus
   initial begin
      bit phase_modes [4];
      int key_len;
      int texts;
      int r;
      bit pressure_done;
      op_type op;
      logic [7:0] data;
      phase_modes   = '{1'b1, 1'b0, 1'b1, 1'b0};
      pressure_done = 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      set_decrypt(1'b0);

      foreach (directed_rows[i]) begin
         if (directed_rows[i].op == OP_KEY_END && !tables_built) begin
            key_len = $urandom_range(0, 40);
            repeat (key_len)
               offer_item(OP_KEY_LETTER,
                          ($urandom_range(0, 3) != 0) ? pick_letter()
                                                      : 8'($urandom_range(0, 255)),
                          1'b0, 8'h00);
         end
         offer_item(directed_rows[i].op, directed_rows[i].data,
                    directed_rows[i].known, directed_rows[i].out);
      end

      foreach (phase_modes[p]) begin
         set_decrypt(phase_modes[p]);
         texts = 0;
         while (texts < 365) begin
            r = $urandom_range(0, 99);
            if (r < 70) begin
               op   = OP_TEXT;
               data = pick_letter();
            end else if (r < 85) begin
               op   = OP_TEXT;
               data = 8'($urandom_range(0, 255));
            end else if (r < 93) begin
               op   = OP_KEY_LETTER;
               data = 8'($urandom_range(0, 255));
            end else if (r < 97) begin
               op   = OP_KEY_END;
               data = 8'($urandom_range(0, 255));
            end else begin
               op   = OP_UNUSED;
               data = 8'($urandom_range(0, 255));
            end
            if (p == 1 && texts == 100 && !pressure_done) begin
               pressure_done = 1'b1;
               rsp_hold      = 1'b1;
               req_no_gap    = 80;
            end
            offer_item(op, data, 1'b0, 8'h00);
            if (op == OP_TEXT)
               texts++;
         end
      end

      req_tvalid <= 1'b0;
      while (out_bytes_due.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (mismatch_count == 0 && out_bytes_due.size() == 0) begin
         $display("keyword_substitution_cipher_core regression: pass");
      end else begin
         $display("keyword_substitution_cipher_core regression: fail");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("keyword_substitution_cipher_core regression: fail");
      $finish;
   end

endmodule
